### rtl/qvr_pkg.sv
package qvr_pkg;

   // Field widths
   localparam int COORD_W = 16;
   localparam int QUAT_W  = 16;

   // Q2.14 quaternion: products of two components carry 28 fraction bits
   localparam int FRAC_W = 2 * (QUAT_W - 2);
   localparam int SQ_W   = 2 * QUAT_W;
   // Matrix coefficients reach +-2^(SQ_W) in magnitude, keep some headroom
   localparam int COEF_W = SQ_W + 3;
   localparam int PROD_W = COEF_W + COORD_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int SH_W   = SUM_W - FRAC_W;

   // Item pipeline depth: capture, two alignment stages, multiply, sum, round
   localparam int DEPTH = 6;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [QUAT_W-1:0]  quat_type;
   typedef logic signed [SQ_W-1:0]    sq_type;
   typedef logic signed [COEF_W-1:0]  coef_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [SH_W-1:0]    sh_type;

   // Row-major 3x3 rotation matrix in Q28
   typedef logic [8:0][COEF_W-1:0] mat_type;

   localparam quat_type  QUAT_ONE   = QUAT_W'(64'sd1 <<< (QUAT_W - 2));
   localparam sum_type   ROUND_HALF = SUM_W'(64'sd1 <<< (FRAC_W - 1));
   localparam sh_type    SAT_HI     = SH_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
   localparam sh_type    SAT_LO     = SH_W'(-(64'sd1 <<< (COORD_W - 1)));
   localparam coord_type COORD_MAX  = COORD_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
   localparam coord_type COORD_MIN  = COORD_W'(-(64'sd1 <<< (COORD_W - 1)));

   typedef enum logic [1:0] {
      CSR_QUAT_X,
      CSR_QUAT_Y,
      CSR_QUAT_Z,
      CSR_QUAT_W
   } csr_index_type;

endpackage

### rtl/qvr_coef.sv
module qvr_coef (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  qvr_pkg::csr_index_type      csr_index,
   input  logic [qvr_pkg::QUAT_W-1:0]  csr_wdata,
   output qvr_pkg::mat_type            matrix_ff
);
   import qvr_pkg::*;

   quat_type quat_x_ff, quat_y_ff, quat_z_ff, quat_w_ff;

   // products of the quaternion components
   sq_type xx_ff, yy_ff, zz_ff, ww_ff;
   sq_type xy_ff, xz_ff, yz_ff;
   sq_type wx_ff, wy_ff, wz_ff;

   mat_type  matrix_in;
   coef_type s_in;

   // quaternion registers, reset to identity
   always_ff @(posedge clock) begin
      if (reset) begin
         quat_x_ff <= '0;
         quat_y_ff <= '0;
         quat_z_ff <= '0;
         quat_w_ff <= QUAT_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUAT_X: quat_x_ff <= csr_wdata;
            CSR_QUAT_Y: quat_y_ff <= csr_wdata;
            CSR_QUAT_Z: quat_z_ff <= csr_wdata;
            CSR_QUAT_W: quat_w_ff <= csr_wdata;
         endcase
      end
   end

   // first stage: ten component products
   always_ff @(posedge clock) begin
      xx_ff <= quat_x_ff * quat_x_ff;
      yy_ff <= quat_y_ff * quat_y_ff;
      zz_ff <= quat_z_ff * quat_z_ff;
      ww_ff <= quat_w_ff * quat_w_ff;
      xy_ff <= quat_x_ff * quat_y_ff;
      xz_ff <= quat_x_ff * quat_z_ff;
      yz_ff <= quat_y_ff * quat_z_ff;
      wx_ff <= quat_w_ff * quat_x_ff;
      wy_ff <= quat_w_ff * quat_y_ff;
      wz_ff <= quat_w_ff * quat_z_ff;
   end

   // second stage: (w^2 - |u|^2) I + 2 u u^T + 2 w [u]x
   always_comb begin
      s_in = COEF_W'(ww_ff) - COEF_W'(xx_ff) - COEF_W'(yy_ff) - COEF_W'(zz_ff);
      matrix_in[0] = s_in + (COEF_W'(xx_ff) <<< 1);
      matrix_in[1] = (COEF_W'(xy_ff) - COEF_W'(wz_ff)) <<< 1;
      matrix_in[2] = (COEF_W'(xz_ff) + COEF_W'(wy_ff)) <<< 1;
      matrix_in[3] = (COEF_W'(xy_ff) + COEF_W'(wz_ff)) <<< 1;
      matrix_in[4] = s_in + (COEF_W'(yy_ff) <<< 1);
      matrix_in[5] = (COEF_W'(yz_ff) - COEF_W'(wx_ff)) <<< 1;
      matrix_in[6] = (COEF_W'(xz_ff) - COEF_W'(wy_ff)) <<< 1;
      matrix_in[7] = (COEF_W'(yz_ff) + COEF_W'(wx_ff)) <<< 1;
      matrix_in[8] = s_in + (COEF_W'(zz_ff) <<< 1);
   end

   always_ff @(posedge clock) begin
      matrix_ff <= matrix_in;
   end

endmodule

### rtl/qvr_datapath.sv
module qvr_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  qvr_pkg::coord_type   req_vec_x,
   input  qvr_pkg::coord_type   req_vec_y,
   input  qvr_pkg::coord_type   req_vec_z,
   input  qvr_pkg::mat_type     matrix,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output qvr_pkg::coord_type   rsp_out_x,
   output qvr_pkg::coord_type   rsp_out_y,
   output qvr_pkg::coord_type   rsp_out_z,
   output logic                 rsp_clipped
);
   import qvr_pkg::*;

   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] en;

   // stages 0..2: vector capture and alignment with the coefficient pipeline
   coord_type vec_ff [3][3];
   // stage 3: nine partial products
   prod_type  prod_ff [9];
   prod_type  prod_in [9];
   // stage 4: row sums with rounding offset
   sum_type   sum_ff [3];
   sum_type   sum_in [3];
   // stage 5: output register
   coord_type out_ff [3];
   coord_type out_in [3];
   logic      clip_ff;
   logic      clip_in;
   sh_type    sh [3];

   // a stage loads when it is empty or its content moves on
   always_comb begin
      en[DEPTH-1] = !vld_ff[DEPTH-1] || rsp_ready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // vector capture and delay line
   always_ff @(posedge clock) begin
      if (en[0]) begin
         vec_ff[0][0] <= req_vec_x;
         vec_ff[0][1] <= req_vec_y;
         vec_ff[0][2] <= req_vec_z;
      end
      if (en[1]) begin
         vec_ff[1] <= vec_ff[0];
      end
      if (en[2]) begin
         vec_ff[2] <= vec_ff[1];
      end
   end

   // matrix times vector, one multiplier per coefficient
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[3*r+c] = $signed(matrix[3*r+c]) * $signed(vec_ff[2][c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         prod_ff <= prod_in;
      end
   end

   // row sums, plus half an LSB for round-half-up
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'(prod_ff[3*r]) + SUM_W'(prod_ff[3*r+1])
                   + SUM_W'(prod_ff[3*r+2]) + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         sum_ff <= sum_in;
      end
   end

   // drop fraction bits and saturate
   always_comb begin
      clip_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         sh[r] = $signed(sum_ff[r][SUM_W-1:FRAC_W]);
         if (sh[r] > SAT_HI) begin
            out_in[r] = COORD_MAX;
            clip_in   = 1'b1;
         end else if (sh[r] < SAT_LO) begin
            out_in[r] = COORD_MIN;
            clip_in   = 1'b1;
         end else begin
            out_in[r] = sh[r][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         out_ff  <= out_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid   = vld_ff[DEPTH-1];
   assign rsp_out_x   = out_ff[0];
   assign rsp_out_y   = out_ff[1];
   assign rsp_out_z   = out_ff[2];
   assign rsp_clipped = clip_ff;

   // an accepted beat lands in the capture stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted beat missing from capture stage");

   // a blocked sum stage keeps its beat and the sums of rows 0 and 2
   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] && !en[4] |=> vld_ff[4] && $stable(sum_ff[0]) && $stable(sum_ff[2]))
      else $error("sum stage lost or changed a stalled beat");

   // a clipped result has at least one component on a rail
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         (rsp_out_x == COORD_MAX || rsp_out_x == COORD_MIN ||
          rsp_out_y == COORD_MAX || rsp_out_y == COORD_MIN ||
          rsp_out_z == COORD_MAX || rsp_out_z == COORD_MIN))
      else $error("clipped flag without a saturated component");

endmodule

### rtl/quaternion_vector_rotate.sv
// Rotates a signed 3D vector by the quaternion held in the four Q2.14 CSRs
// (x, y, z at index 0..2, w at index 3; reset is the identity). The result is
// q*v*conj(q) without normalization, so a non-unit q also scales by |q|^2;
// each component is rounded half up and saturated, and rsp_clipped flags
// any saturation. One beat is accepted per clock unless back-pressure on
// rsp_ready stalls the six-stage item pipeline (capture, two alignment
// stages, multiply, row sum, round/saturate). A CSR write reaches the
// rotation matrix through the coefficient pipeline (quaternion register,
// component products, matrix register); beats taken at or after the write
// cycle see the new quaternion.
// Write the CSRs only while no beat is in flight.
module quaternion_vector_rotate (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  qvr_pkg::csr_index_type      csr_index,
   input  logic [qvr_pkg::QUAT_W-1:0]  csr_wdata,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  qvr_pkg::coord_type          req_vec_x,
   input  qvr_pkg::coord_type          req_vec_y,
   input  qvr_pkg::coord_type          req_vec_z,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output qvr_pkg::coord_type          rsp_out_x,
   output qvr_pkg::coord_type          rsp_out_y,
   output qvr_pkg::coord_type          rsp_out_z,
   output logic                        rsp_clipped
);
   import qvr_pkg::*;

   mat_type matrix;

   // quaternion registers and rotation matrix
   qvr_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .matrix_ff (matrix)
   );

   // per-vector pipeline
   qvr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_vec_x   (req_vec_x),
      .req_vec_y   (req_vec_y),
      .req_vec_z   (req_vec_z),
      .matrix      (matrix),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_clipped (rsp_clipped)
   );

endmodule
